/* src/strip_index_code_emitter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the strip index code emitter.
// ----------------------------------------------------------------------------
`ifndef STRIP_INDEX_CODE_EMITTER_ASSERT_SVH
`define STRIP_INDEX_CODE_EMITTER_ASSERT_SVH

// Checked only out of reset.
`define SICE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sice: property violated");

// Checked at every rising clock edge, reset included.
`define SICE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sice: property violated around reset");

`endif

/* src/sice_pkg.sv */
// ----------------------------------------------------------------------------
// sice_pkg
// Shared types and constants of the strip index code emitter.
// ----------------------------------------------------------------------------
package sice_pkg;

    localparam int INDEX_BITS_DEF = 32;
    localparam int VERTEX_BITS    = 32;
    localparam int DELTA_BITS     = 32;

    // result kinds
    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_NIB = 1'b1;

    // triangle codes
    localparam logic [3:0] CODE_CONT    = 4'd0;
    localparam logic [3:0] CODE_SWAP    = 4'd1;
    localparam logic [3:0] CODE_OTHER   = 4'd2;
    localparam logic [3:0] CODE_RESTART = 4'd3;

    // nibble coding
    localparam logic [3:0] NIB_ESCAPE  = 4'd15;
    localparam logic [DELTA_BITS-1:0] SHORT_LIMIT = DELTA_BITS'(15);
    localparam logic [DELTA_BITS-1:0] GROUP_MAX   = DELTA_BITS'(7);
    localparam int GROUP_BITS = 3;

    localparam logic [1:0] POS_THIRD = 2'd2;
    localparam logic [1:0] POS_FULL  = 2'd3;
    localparam logic [1:0] SEL_DONE  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CODE,
        ST_ESC,
        ST_GRP
    } state_t;

    typedef enum logic [1:0] {
        OUT_CODE,
        OUT_ESC,
        OUT_GRP
    } out_sel_t;

    typedef struct packed {
        logic     restart;     // restart beat: clear position
        logic     shift;       // index beat: push history, bump position
        logic     start_tri3;  // first triangle of a strip
        logic     start_tri;   // later triangle
        logic     load_next;   // load delta of next history entry
        logic     shift_grp;   // drop the emitted 3-bit group
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic       restart;
        logic [1:0] pos;
        logic       degen;
        logic       tri3;
        logic       code_last;
        logic       final_delta;
        logic       lt15;
        logic       le7;
    } stat_t;

endpackage

/* src/sice_datapath.sv */
// ----------------------------------------------------------------------------
// sice_datapath
// Index history, new-vertex counter, delta register and result formatting.
// ----------------------------------------------------------------------------
module sice_datapath #(
    parameter int INDEX_BITS = sice_pkg::INDEX_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sice_pkg::VERTEX_BITS-1:0]   vertex_index,
    input  sice_pkg::cmd_t                     cmd,
    output sice_pkg::stat_t                    stat,
    output logic                               code_kind,
    output logic [3:0]                         code_value
);

    localparam int DB = sice_pkg::DELTA_BITS;

    logic [INDEX_BITS-1:0] third_reg, third_next;
    logic [INDEX_BITS-1:0] second_reg, second_next;
    logic [INDEX_BITS-1:0] last_reg, last_next;
    logic [INDEX_BITS-1:0] nnv_reg, nnv_next;
    logic [1:0]            pos_reg, pos_next;
    logic [1:0]            sel_reg, sel_next;
    logic                  tri3_reg, tri3_next;
    logic                  code_last_reg, code_last_next;
    logic [3:0]            code_reg, code_next;
    logic [DB-1:0]         delta_reg, delta_next;

    logic [INDEX_BITS-1:0] cidx;
    logic [INDEX_BITS-1:0] sel_idx;
    logic                  swap;
    logic                  match_c;
    logic                  match_sel;
    logic [DB-1:0]         delta_c;
    logic [DB-1:0]         delta_sel;

    assign cidx      = vertex_index[INDEX_BITS-1:0];
    assign swap      = (last_reg == third_reg);
    assign match_c   = (cidx == nnv_reg);
    assign delta_c   = DB'(nnv_reg) - DB'(cidx);

    always_comb
    begin
        unique case (sel_reg)
            2'd0:    sel_idx = third_reg;
            2'd1:    sel_idx = second_reg;
            default: sel_idx = last_reg;
        endcase
    end

    assign match_sel = (sel_idx == nnv_reg);
    assign delta_sel = DB'(nnv_reg) - DB'(sel_idx);

    always_comb
    begin
        third_next     = third_reg;
        second_next    = second_reg;
        last_next      = last_reg;
        nnv_next       = nnv_reg;
        pos_next       = pos_reg;
        sel_next       = sel_reg;
        tri3_next      = tri3_reg;
        code_last_next = code_last_reg;
        code_next      = code_reg;
        delta_next     = delta_reg;

        if (cmd.restart)
        begin
            pos_next = 2'd0;
        end
        if (cmd.shift)
        begin
            third_next  = second_reg;
            second_next = last_reg;
            last_next   = cidx;
            if (pos_reg != sice_pkg::POS_FULL)
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
        if (cmd.start_tri3)
        begin
            code_next      = sice_pkg::CODE_RESTART;
            code_last_next = 1'b0;
            tri3_next      = 1'b1;
            sel_next       = 2'd0;
        end
        if (cmd.start_tri)
        begin
            tri3_next      = 1'b0;
            code_last_next = match_c;
            if (match_c)
            begin
                code_next = swap ? sice_pkg::CODE_SWAP : sice_pkg::CODE_CONT;
                nnv_next  = nnv_reg + INDEX_BITS'(1);
            end
            else
            begin
                code_next  = sice_pkg::CODE_OTHER;
                delta_next = {delta_c[DB-2:0], swap};
            end
        end
        if (cmd.load_next)
        begin
            delta_next = delta_sel;
            sel_next   = sel_reg + 2'd1;
            if (match_sel)
            begin
                nnv_next = nnv_reg + INDEX_BITS'(1);
            end
        end
        if (cmd.shift_grp)
        begin
            delta_next = delta_reg >> sice_pkg::GROUP_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            third_reg  <= '0;
            second_reg <= '0;
            last_reg   <= '0;
            nnv_reg    <= '0;
            pos_reg    <= '0;
            sel_reg    <= '0;
            tri3_reg   <= 1'b0;
        end
        else
        begin
            third_reg  <= third_next;
            second_reg <= second_next;
            last_reg   <= last_next;
            nnv_reg    <= nnv_next;
            pos_reg    <= pos_next;
            sel_reg    <= sel_next;
            tri3_reg   <= tri3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_last_reg <= code_last_next;
        code_reg      <= code_next;
        delta_reg     <= delta_next;
    end

    always_comb
    begin
        stat.restart     = &cidx;
        stat.pos         = pos_reg;
        stat.degen       = (cidx == second_reg);
        stat.tri3        = tri3_reg;
        stat.code_last   = code_last_reg;
        stat.final_delta = !tri3_reg || (sel_reg == sice_pkg::SEL_DONE);
        stat.lt15        = (delta_reg < sice_pkg::SHORT_LIMIT);
        stat.le7         = (delta_reg <= sice_pkg::GROUP_MAX);
    end

    always_comb
    begin
        unique case (cmd.out_sel)
            sice_pkg::OUT_CODE:
            begin
                code_kind  = sice_pkg::KIND_TRI;
                code_value = code_reg;
            end
            sice_pkg::OUT_ESC:
            begin
                code_kind  = sice_pkg::KIND_NIB;
                code_value = stat.lt15 ? delta_reg[3:0] : sice_pkg::NIB_ESCAPE;
            end
            default:
            begin
                // 3-bit group, bit 3 flags a further group
                code_kind  = sice_pkg::KIND_NIB;
                code_value = {!stat.le7, delta_reg[2:0]};
            end
        endcase
    end

endmodule

/* src/sice_ctrl.sv */
// ----------------------------------------------------------------------------
// sice_ctrl
// Sequencer: accepts indices and steps through the code and nibble beats.
// ----------------------------------------------------------------------------
module sice_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             last_of_run,
    input  sice_pkg::stat_t  stat,
    output sice_pkg::cmd_t   cmd
);

    sice_pkg::state_t state_reg, state_next;
    logic             in_fire;
    logic             tri_start;

    assign in_fire   = in_valid && in_ready;
    assign tri_start = !stat.restart
                    && ((stat.pos == sice_pkg::POS_THIRD)
                     || ((stat.pos == sice_pkg::POS_FULL) && !stat.degen));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sice_pkg::ST_IDLE:
            begin
                if (in_valid && tri_start)
                begin
                    state_next = sice_pkg::ST_CODE;
                end
            end
            sice_pkg::ST_CODE:
            begin
                if (out_ready)
                begin
                    state_next = stat.code_last ? sice_pkg::ST_IDLE : sice_pkg::ST_ESC;
                end
            end
            sice_pkg::ST_ESC:
            begin
                if (out_ready)
                begin
                    priority if (!stat.lt15)
                        state_next = sice_pkg::ST_GRP;
                    else if (stat.final_delta)
                        state_next = sice_pkg::ST_IDLE;
                    else
                        state_next = sice_pkg::ST_ESC;
                end
            end
            default:
            begin
                if (out_ready)
                begin
                    priority if (!stat.le7)
                        state_next = sice_pkg::ST_GRP;
                    else if (stat.final_delta)
                        state_next = sice_pkg::ST_IDLE;
                    else
                        state_next = sice_pkg::ST_ESC;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        last_of_run = 1'b0;
        cmd         = '0;
        cmd.out_sel = sice_pkg::OUT_CODE;
        unique case (state_reg)
            sice_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.restart    = stat.restart;
                    cmd.shift      = !stat.restart;
                    cmd.start_tri3 = !stat.restart && (stat.pos == sice_pkg::POS_THIRD);
                    cmd.start_tri  = tri_start && (stat.pos == sice_pkg::POS_FULL);
                end
            end
            sice_pkg::ST_CODE:
            begin
                out_valid     = 1'b1;
                last_of_run   = stat.code_last;
                cmd.load_next = out_ready && stat.tri3;
            end
            sice_pkg::ST_ESC:
            begin
                out_valid     = 1'b1;
                cmd.out_sel   = sice_pkg::OUT_ESC;
                last_of_run   = stat.lt15 && stat.final_delta;
                cmd.load_next = out_ready && stat.lt15 && !stat.final_delta;
            end
            default:
            begin
                out_valid     = 1'b1;
                cmd.out_sel   = sice_pkg::OUT_GRP;
                last_of_run   = stat.le7 && stat.final_delta;
                cmd.load_next = out_ready && stat.le7 && !stat.final_delta;
                cmd.shift_grp = out_ready && !stat.le7;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sice_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/strip_index_code_emitter.sv */
// ----------------------------------------------------------------------------
// strip_index_code_emitter
// Turns a stream of triangle-strip indices into triangle codes and nibbles.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, vertex_index) takes one strip index per
// beat; an index with all low INDEX_BITS bits set restarts the strip.
// Output channel (out_valid/out_ready) carries one result per beat:
// code_kind/code_value is a 2-bit triangle code or a 4-bit nibble, and
// last_of_run marks the final result of the index that caused it.
// An index is taken while the block is idle; while its results go out,
// in_ready is low. The first result shows the cycle after the accept,
// then one result per cycle while the receiver does not stall. An index
// causes from 0 to 37 results; a plain strip index gives one code. Long
// deltas go out nibble by nibble from the single delta shift register.
// When the receiver stalls, the current result holds and the sequencer
// waits. Reset clears the index history, position and new-vertex counter
// to zero and returns the block to accepting input.
// ----------------------------------------------------------------------------
module strip_index_code_emitter #(
    parameter int INDEX_BITS = sice_pkg::INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sice_pkg::VERTEX_BITS-1:0] vertex_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             code_kind,
    output logic [3:0]                       code_value,
    output logic                             last_of_run
);

    sice_pkg::cmd_t  cmd;
    sice_pkg::stat_t stat;

    sice_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .last_of_run (last_of_run),
        .stat        (stat),
        .cmd         (cmd)
    );

    sice_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_index (vertex_index),
        .cmd          (cmd),
        .stat         (stat),
        .code_kind    (code_kind),
        .code_value   (code_value)
    );

endmodule

/* src/sice_checker.sv */
// ----------------------------------------------------------------------------
// sice_checker
// Port-level checks of the strip index code emitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "strip_index_code_emitter_assert.svh"

module sice_checker #(
    parameter int INDEX_BITS = sice_pkg::INDEX_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [sice_pkg::VERTEX_BITS-1:0] vertex_index,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             code_kind,
    input logic [3:0]                       code_value,
    input logic                             last_of_run
);

    logic [5:0] out_beat;
    logic       restart_beat;

    assign out_beat     = {code_kind, code_value, last_of_run};
    assign restart_beat = &vertex_index[INDEX_BITS-1:0];

    // a stalled result beat holds
    `SICE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat))

    // one index at a time: no intake while results are pending
    `SICE_ASSERT(a_busy_no_intake, out_valid |-> !in_ready)

    // a restart beat produces nothing
    `SICE_ASSERT(a_restart_silent, in_valid && in_ready && restart_beat |=> !out_valid)

    // results of one index come without gaps
    `SICE_ASSERT(a_run_contiguous, out_valid && out_ready && !last_of_run |=> out_valid)
    `SICE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid)

endmodule

bind strip_index_code_emitter sice_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_sice_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vertex_index (vertex_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_kind    (code_kind),
    .code_value   (code_value),
    .last_of_run  (last_of_run)
);

/* verif/strip_index_code_emitter_checker.sv */
// ----------------------------------------------------------------------------
// strip_index_code_emitter_checker
// Watches both channels of the strip index code emitter. Every accepted index
// beat runs through a strip-coding predictor that queues the triangle codes
// and nibbles it should cause. Every accepted result beat is compared field
// by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module strip_index_code_emitter_checker #(
    parameter int INDEX_BITS = sice_pkg::INDEX_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [sice_pkg::VERTEX_BITS-1:0] vertex_index,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             code_kind,
    input  logic [3:0]                       code_value,
    input  logic                             last_of_run,
    output int                               error_count,
    output int                               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DB = sice_pkg::DELTA_BITS;

    typedef struct packed {
        logic       kind;
        logic [3:0] value;
        logic       last;
    } code_beat_t;

    code_beat_t expected_codes[$];

    // strip history and new-vertex counter
    logic [INDEX_BITS-1:0] hist_old = '0;
    logic [INDEX_BITS-1:0] hist_mid = '0;
    logic [INDEX_BITS-1:0] hist_new = '0;
    logic [1:0]            strip_pos = '0;
    logic [INDEX_BITS-1:0] new_vertex_ctr = '0;

    initial error_count = 0;

    function automatic void queue_code(logic kind, logic [3:0] value);
        code_beat_t beat;
        beat.kind  = kind;
        beat.value = value;
        beat.last  = 1'b0;
        expected_codes.push_back(beat);
    endfunction

    // short delta is one nibble; long one is escape, then 3-bit groups LSB first
    function automatic void queue_delta(logic [DB-1:0] delta);
        logic [DB-1:0] rest;
        rest = delta;
        if (rest < sice_pkg::SHORT_LIMIT)
        begin
            queue_code(sice_pkg::KIND_NIB, rest[3:0]);
            return;
        end
        queue_code(sice_pkg::KIND_NIB, sice_pkg::NIB_ESCAPE);
        do
        begin
            queue_code(sice_pkg::KIND_NIB, {rest > sice_pkg::GROUP_MAX, rest[2:0]});
            rest = rest >> sice_pkg::GROUP_BITS;
        end
        while (rest != '0);
    endfunction

    function automatic logic [DB-1:0] delta_and_advance(logic [INDEX_BITS-1:0] idx);
        logic [DB-1:0] delta;
        delta = DB'(new_vertex_ctr) - DB'(idx);
        if (idx == new_vertex_ctr)
            new_vertex_ctr = new_vertex_ctr + 1'b1;
        return delta;
    endfunction

    function automatic void predict_strip_codes(logic [sice_pkg::VERTEX_BITS-1:0] raw);
        logic [INDEX_BITS-1:0] idx;
        logic [DB-1:0]         d_mid;
        logic [DB-1:0]         d_new;
        logic [DB-1:0]         d_cur;
        logic [DB-1:0]         d_other;
        logic                  swap;
        int                    first;
        code_beat_t            tail;
        idx   = raw[INDEX_BITS-1:0];
        first = expected_codes.size();
        if (idx == '1)
        begin
            strip_pos = '0;
            return;
        end
        if (strip_pos == sice_pkg::POS_THIRD)
        begin
            // counter advances between the three deltas, in order
            d_mid = delta_and_advance(hist_mid);
            d_new = delta_and_advance(hist_new);
            d_cur = delta_and_advance(idx);
            queue_code(sice_pkg::KIND_TRI, sice_pkg::CODE_RESTART);
            queue_delta(d_mid);
            queue_delta(d_new);
            queue_delta(d_cur);
        end
        else if (strip_pos == sice_pkg::POS_FULL && idx != hist_mid)
        begin
            swap = (hist_new == hist_old);
            if (idx == new_vertex_ctr)
            begin
                queue_code(sice_pkg::KIND_TRI,
                           swap ? sice_pkg::CODE_SWAP : sice_pkg::CODE_CONT);
                new_vertex_ctr = new_vertex_ctr + 1'b1;
            end
            else
            begin
                queue_code(sice_pkg::KIND_TRI, sice_pkg::CODE_OTHER);
                d_other = DB'(new_vertex_ctr) - DB'(idx);
                queue_delta({d_other[DB-2:0], swap});
            end
        end
        hist_old = hist_mid;
        hist_mid = hist_new;
        hist_new = idx;
        if (strip_pos != sice_pkg::POS_FULL)
            strip_pos = strip_pos + 1'b1;
        if (expected_codes.size() > first)
        begin
            tail = expected_codes.pop_back();
            tail.last = 1'b1;
            expected_codes.push_back(tail);
        end
    endfunction

    function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        code_beat_t want;
        if (!rst_n)
        begin
            expected_codes.delete();
            hist_old = '0;
            hist_mid = '0;
            hist_new = '0;
            strip_pos = '0;
            new_vertex_ctr = '0;
            pending_results <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_strip_codes(vertex_index);
            if (out_valid && out_ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    error_count++;
                    $display({"%0t: unexpected result, expected none, ",
                              "actual kind %0d value %0d last %0d"},
                             $time, code_kind, code_value, last_of_run);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    compare_field("code_kind", {3'b0, want.kind}, {3'b0, code_kind});
                    compare_field("code_value", want.value, code_value);
                    compare_field("last_of_run", {3'b0, want.last}, {3'b0, last_of_run});
                end
            end
            pending_results <= expected_codes.size();
        end
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the strip index code emitter. A directed strip
// walk hits every triangle code, degenerate triangles, restarts, nibble
// escape limits and the longest output run; random strips follow, mostly
// fresh sequential vertices with reuse, near and far deltas and restarts.
// The sender runs in bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = sice_pkg::VERTEX_BITS;
    localparam logic [VB-1:0] STRIP_RESTART = '1;
    localparam int RANDOM_INDICES = 360;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [VB-1:0] vertex_index;
    logic          out_valid;
    logic          out_ready;
    logic          code_kind;
    logic [3:0]    code_value;
    logic          last_of_run;
    int            error_count;
    int            pending_results;

    int            burst_left = 4;
    logic [VB-1:0] recent_idx[4] = '{default: '0};

    strip_index_code_emitter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_kind    (code_kind),
        .code_value   (code_value),
        .last_of_run  (last_of_run)
    );

    strip_index_code_emitter_checker code_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .vertex_index    (vertex_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .code_kind       (code_kind),
        .code_value      (code_value),
        .last_of_run     (last_of_run),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // one index beat; valid stays up across back-to-back beats of a burst
    task automatic send_index(input logic [VB-1:0] idx);
        in_valid <= 1'b1;
        vertex_index <= idx;
        do @(posedge clk); while (!in_ready);
        if (idx != STRIP_RESTART)
            recent_idx = '{idx, recent_idx[0], recent_idx[1], recent_idx[2]};
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // receiver back-pressure, changing character every so often
    initial
    begin
        int stall_mode;
        int phase;
        out_ready <= 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 120))
            begin
                @(posedge clk);
                phase++;
                unique case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= (phase % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [VB-1:0] directed_seq[$];
        logic [VB-1:0] next_idx;
        logic [VB-1:0] fresh;
        int            pick;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        vertex_index <= '0;
        // first triangle, continue, degenerate, swap; deltas 14/15/16 around
        // the escape; restarts; longest run from three far indices; short strip
        directed_seq = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd2, 32'd4,
                         STRIP_RESTART, 32'hFFFF_FFF7, 32'hFFFF_FFF6, 32'hFFFF_FFF5,
                         32'd5, 32'hFFFF_FFF5,
                         STRIP_RESTART, STRIP_RESTART,
                         32'h7FFF_FFF0, 32'h7FFF_FFF1, 32'h7FFF_FFF2, 32'h7FFF_FFF3,
                         32'hFFFF_FFFE,
                         STRIP_RESTART, 32'd0, STRIP_RESTART,
                         32'd6, 32'd7, 32'd8, 32'd9};
        fresh = 32'd10;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i])
            send_index(directed_seq[i]);

        for (int n = 0; n < RANDOM_INDICES; n++)
        begin
            if (n == RANDOM_INDICES / 2)
            begin
                // drain completely before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results != 0) @(posedge clk);
                repeat (3) @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                next_idx = fresh;
                fresh++;
            end
            else if (pick < 73)
                next_idx = recent_idx[$urandom_range(0, 3)];
            else if (pick < 83)
                next_idx = fresh - $urandom_range(1, 40);
            else if (pick < 88)
                next_idx = fresh + $urandom_range(1, 5000);
            else if (pick < 95)
                next_idx = $urandom();
            else
                next_idx = STRIP_RESTART;
            send_index(next_idx);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/sice_pkg.sv
src/sice_datapath.sv
src/sice_ctrl.sv
src/strip_index_code_emitter.sv
src/sice_checker.sv
verif/strip_index_code_emitter_checker.sv
verif/testbench.sv
